// ===== rtl/hcr_pkg.sv =====
// ============================================================================
// hcr_pkg: shared types and constants for the height color ramp
// Stop heights, colors, segment spans and reciprocals of the color ramp.
// ============================================================================
package hcr_pkg;

	// Height format: signed, 8 fraction bits
	localparam int HEIGHT_W  = 24;
	localparam int CHAN_W    = 8;
	localparam int STOP_COUNT = 15;
	localparam int IDX_W     = $clog2(STOP_COUNT);
	localparam int WEIGHT_BITS = 16;
	// Offset inside one segment is below the widest span (7680)
	localparam int DELTA_W   = 13;
	localparam int SPAN_W    = 13;
	// Reciprocal is floor(2^(WEIGHT_BITS+DELTA_W) / span)
	localparam int RECIP_W   = 23;
	localparam int NUM_W     = DELTA_W + WEIGHT_BITS;
	localparam int PROD_W    = DELTA_W + RECIP_W;
	localparam int BLEND_W   = CHAN_W + 1 + WEIGHT_BITS + 1;

	typedef logic [CHAN_W-1:0] chan_t;
	typedef logic [IDX_W-1:0]  idx_t;

	// Control that travels with each item down the pipe
	typedef struct packed {
		logic vld;   // stage holds an item
		logic low;   // at or below the first stop
		logic top;   // at or above the last stop
		idx_t idx;   // segment (lower stop) index
	} hcr_ctl_t;

	// Stop heights on the height grid (rounded to nearest)
	localparam logic signed [HEIGHT_W-1:0] STOP_H [STOP_COUNT] = '{
		-24'sd2560, -24'sd1280, -24'sd512, 24'sd0, 24'sd77, 24'sd384, 24'sd768,
		24'sd2048, 24'sd3840, 24'sd6400, 24'sd8960, 24'sd12800, 24'sd17920,
		24'sd23040, 24'sd30720
	};

	// Stop colors, {blue, green, red}
	localparam logic [3*CHAN_W-1:0] STOP_RGB [STOP_COUNT] = '{
		24'h884410, 24'h995518, 24'haa6622, 24'hbb8844, 24'h7799aa,
		24'h668899, 24'h448866, 24'h337733, 24'h336644, 24'h336655,
		24'h446666, 24'h557777, 24'h778888, 24'h777777, 24'haaaaaa
	};

	// Width of segment i (stop i to stop i+1); last entry unused
	localparam logic [SPAN_W-1:0] SEG_SPAN [STOP_COUNT] = '{
		13'd1280, 13'd768, 13'd512, 13'd77, 13'd307, 13'd384, 13'd1280,
		13'd1792, 13'd2560, 13'd2560, 13'd3840, 13'd5120, 13'd5120,
		13'd7680, 13'd7680
	};

	// floor(2^29 / span) per segment; last entry unused
	localparam logic [RECIP_W-1:0] SEG_RECIP [STOP_COUNT] = '{
		23'd419430, 23'd699050, 23'd1048576, 23'd6972349, 23'd1748765,
		23'd1398101, 23'd419430, 23'd299593, 23'd209715, 23'd209715,
		23'd139810, 23'd104857, 23'd104857, 23'd69905, 23'd69905
	};

	// One channel of a stop color
	function automatic chan_t stop_chan(input idx_t idx, input logic [1:0] ch);
		logic [3*CHAN_W-1:0] rgb;
		begin
			rgb = STOP_RGB[idx];
			case (ch)
				2'd0: stop_chan = rgb[CHAN_W-1:0];
				2'd1: stop_chan = rgb[2*CHAN_W-1:CHAN_W];
				default: stop_chan = rgb[3*CHAN_W-1:2*CHAN_W];
			endcase
		end
	endfunction

endpackage

// ===== rtl/hcr_locate.sv =====
// ============================================================================
// hcr_locate: offset and segment search
// Saturating offset from water level, stop compare, offset within segment.
// ============================================================================
module hcr_locate import hcr_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_vld,
	input  logic signed [HEIGHT_W-1:0] height,
	input  logic signed [HEIGHT_W-1:0] water_level,
	output hcr_ctl_t                   ctl_s3,
	output logic [DELTA_W-1:0]         delta_s3
);

	logic                       vld_s1;
	logic signed [HEIGHT_W-1:0] h_s1;
	hcr_ctl_t                   ctl_s2;
	logic signed [HEIGHT_W-1:0] h_s2;

	logic signed [HEIGHT_W:0]   diff;
	logic signed [HEIGHT_W-1:0] h_sat;
	idx_t                       seg_idx;
	logic signed [HEIGHT_W-1:0] rel;

	// Stage 1: saturating subtract
	always_comb begin
		diff = {height[HEIGHT_W-1], height} - {water_level[HEIGHT_W-1], water_level};
		if (diff[HEIGHT_W] != diff[HEIGHT_W-1])
			h_sat = diff[HEIGHT_W] ? {1'b1, {(HEIGHT_W-1){1'b0}}}
			                       : {1'b0, {(HEIGHT_W-1){1'b1}}};
		else
			h_sat = diff[HEIGHT_W-1:0];
	end

	// Stage 2: compare against inner stops, highest match wins
	always_comb begin
		seg_idx = '0;
		for (int k = 1; k < STOP_COUNT - 1; k++) begin
			if (h_s1 >= STOP_H[k])
				seg_idx = IDX_W'(k);
		end
	end

	// Stage 3: offset from the lower stop of the segment
	assign rel = h_s2 - STOP_H[ctl_s2.idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else if (en) begin
			vld_s1     <= in_vld;
			ctl_s2.vld <= vld_s1;
			ctl_s2.low <= (h_s1 <= STOP_H[0]);
			ctl_s2.top <= (h_s1 >= STOP_H[STOP_COUNT-1]);
			ctl_s2.idx <= seg_idx;
			ctl_s3     <= ctl_s2;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (en) begin
			h_s1     <= h_sat;
			h_s2     <= h_s1;
			delta_s3 <= ctl_s2.low ? '0 : rel[DELTA_W-1:0];
		end
	end

endmodule

// ===== rtl/hcr_divide.sv =====
// ============================================================================
// hcr_divide: segment weight
// t = floor(delta * 2^16 / span) by reciprocal multiply and one correction.
// ============================================================================
module hcr_divide import hcr_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  hcr_ctl_t               ctl_s3,
	input  logic [DELTA_W-1:0]     delta_s3,
	output hcr_ctl_t               ctl_s6,
	output logic [WEIGHT_BITS-1:0] t_s6
);

	hcr_ctl_t               ctl_s4, ctl_s5;
	logic [DELTA_W-1:0]     delta_s4, delta_s5;
	logic [WEIGHT_BITS-1:0] q0_s4, q0_s5;
	logic [NUM_W-1:0]       qs_s5;

	logic [PROD_W-1:0]      est;
	logic [NUM_W-1:0]       qs;
	logic [NUM_W-1:0]       rem;
	logic [SPAN_W-1:0]      span5;

	// Stage 4: estimate, low by at most one
	assign est = PROD_W'(delta_s3) * PROD_W'(SEG_RECIP[ctl_s3.idx]);

	// Stage 5: back-multiply the estimate
	assign qs = NUM_W'(q0_s4) * NUM_W'(SEG_SPAN[ctl_s4.idx]);

	// Stage 6: remainder and correction
	assign span5 = SEG_SPAN[ctl_s5.idx];
	assign rem   = {delta_s5, {WEIGHT_BITS{1'b0}}} - qs_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s4 <= '0;
			ctl_s5 <= '0;
			ctl_s6 <= '0;
		end else if (en) begin
			ctl_s4 <= ctl_s3;
			ctl_s5 <= ctl_s4;
			ctl_s6 <= ctl_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			delta_s4 <= delta_s3;
			q0_s4    <= est[DELTA_W +: WEIGHT_BITS];
			delta_s5 <= delta_s4;
			q0_s5    <= q0_s4;
			qs_s5    <= qs;
			t_s6     <= (rem >= NUM_W'(span5)) ? q0_s5 + 1'b1 : q0_s5;
		end
	end

`ifndef ASSERT_OFF
	// Reciprocal error must leave the remainder below two spans
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_s5.vld && !ctl_s5.top |-> rem < {NUM_W'(span5), 1'b0})
		else $error("weight correction out of range");
`endif

endmodule

// ===== rtl/hcr_blend.sv =====
// ============================================================================
// hcr_blend: channel interpolation
// Per channel a + (b - a) * t with rounding; end colors outside the ramp.
// ============================================================================
module hcr_blend import hcr_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  hcr_ctl_t               ctl_s6,
	input  logic [WEIGHT_BITS-1:0] t_s6,
	output logic                   vld_s8,
	output logic [3*CHAN_W-1:0]    rgb_s8
);

	hcr_ctl_t                  ctl_s7;
	logic signed [BLEND_W-1:0] prod_s7 [3];
	logic signed [BLEND_W-1:0] prod    [3];
	logic signed [BLEND_W-1:0] acc     [3];
	logic [3*CHAN_W-1:0]       rgb;

	// Stage 7: weighted difference per channel
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			prod[c] = BLEND_W'($signed({1'b0, stop_chan(ctl_s6.idx + 1'b1, 2'(c))})
			        - $signed({1'b0, stop_chan(ctl_s6.idx, 2'(c))}))
			        * $signed({1'b0, t_s6});
		end
	end

	// Stage 8: add base, round, pick end color when clamped
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			acc[c] = $signed({2'b00, stop_chan(ctl_s7.idx, 2'(c)), {WEIGHT_BITS{1'b0}}})
			       + prod_s7[c]
			       + $signed(BLEND_W'(1) << (WEIGHT_BITS - 1));
			rgb[c*CHAN_W +: CHAN_W] = acc[c][WEIGHT_BITS +: CHAN_W];
		end
		if (ctl_s7.top)
			rgb = STOP_RGB[STOP_COUNT-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s7 <= '0;
			vld_s8 <= 1'b0;
		end else if (en) begin
			ctl_s7 <= ctl_s6;
			vld_s8 <= ctl_s7.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++)
				prod_s7[c] <= prod[c];
			rgb_s8 <= rgb;
		end
	end

endmodule

// ===== rtl/height_color_ramp_unit.sv =====
// ============================================================================
// height_color_ramp_unit: height sample to RGB color ramp
// Top level: water level register, stream ports and pipeline control.
// ============================================================================
// Takes one height sample per clock while the output is not stalled and
// returns one RGB color per sample. The height is offset by the water level
// (saturating), located among fifteen stops, and blended linearly between
// the two stop colors; the segment weight comes from a reciprocal multiply
// with one correction step. The eight register stages advance together: a
// stall on the output freezes the whole pipeline, and s_tready is low only
// while a result waits on m_tdata and m_tready is low.
module height_color_ramp_unit import hcr_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [HEIGHT_W-1:0]   cfg_data,  // water_level
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [HEIGHT_W-1:0]   s_tdata,   // height
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [3*CHAN_W-1:0]   m_tdata    // red, green, blue
);

	logic                       en;
	logic signed [HEIGHT_W-1:0] water_level_q;
	hcr_ctl_t                   ctl_s3, ctl_s6;
	logic [DELTA_W-1:0]         delta_s3;
	logic [WEIGHT_BITS-1:0]     t_s6;

	// Pipeline moves when the output register is free or being taken
	assign en        = !m_tvalid || m_tready;
	assign s_tready  = en;
	assign cfg_ready = 1'b1;

	// Water level register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			water_level_q <= '0;
		else if (cfg_valid && cfg_ready)
			water_level_q <= cfg_data;
	end

	hcr_locate u_locate (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.in_vld      (s_tvalid),
		.height      (s_tdata),
		.water_level (water_level_q),
		.ctl_s3      (ctl_s3),
		.delta_s3    (delta_s3)
	);

	hcr_divide u_divide (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.ctl_s3   (ctl_s3),
		.delta_s3 (delta_s3),
		.ctl_s6   (ctl_s6),
		.t_s6     (t_s6)
	);

	hcr_blend u_blend (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.ctl_s6 (ctl_s6),
		.t_s6   (t_s6),
		.vld_s8 (m_tvalid),
		.rgb_s8 (m_tdata)
	);

`ifndef ASSERT_OFF
	// Input side never blocks while the output register is empty
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");

	// Water level changes only through a config write
	a_wl_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(cfg_valid) |-> $stable(water_level_q))
		else $error("water level changed without write");

	// A new result appears only after the pipe advanced
	a_out_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(en))
		else $error("result appeared without pipeline advance");
`endif

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tb_top: self-checking bench for height_color_ramp_unit
// Drives height samples on the slave stream and water levels on the config
// channel, predicts each RGB color, and compares the master stream in order.
// ============================================================================
module tb_top import hcr_pkg::*; ();

	localparam int CLK_PERIOD  = 4;
	localparam int RESET_CYC   = 9;
	localparam int PIPE_LAT    = 8;
	localparam int DRAIN_CYC   = 4 * PIPE_LAT;
	localparam int HOLD_CYC    = 200;
	localparam int PHASES      = 5;
	localparam int PHASE_ITEMS = 266;
	localparam int CYCLE_LIMIT = 200000;
	localparam int MAX_SHOWN   = 10;
	localparam int FRAC_BITS   = 8;
	localparam int LAST        = STOP_COUNT - 1;
	localparam longint H_MIN   = -(longint'(1) << (HEIGHT_W - 1));
	localparam longint H_MAX   = (longint'(1) << (HEIGHT_W - 1)) - 1;

	// Color as it sits on m_tdata: red in the low byte
	typedef struct packed {
		chan_t blue;
		chan_t green;
		chan_t red;
	} color_t;

	// Ramp stops: height in thousandths of a unit, color {blue, green, red}
	localparam int STOP_MILLI [STOP_COUNT] = '{
		-10000, -5000, -2000, 0, 300, 1500, 3000, 8000,
		15000, 25000, 35000, 50000, 70000, 90000, 120000
	};
	localparam logic [3*CHAN_W-1:0] STOP_COLOR [STOP_COUNT] = '{
		24'h884410, 24'h995518, 24'haa6622, 24'hbb8844, 24'h7799aa,
		24'h668899, 24'h448866, 24'h337733, 24'h336644, 24'h336655,
		24'h446666, 24'h557777, 24'h778888, 24'h777777, 24'haaaaaa
	};

	// Colors that can be read straight off the stop list
	localparam color_t COL_DEEP  = 24'h884410;  // first stop
	localparam color_t COL_SEA   = 24'hbb8844;  // water surface stop
	localparam color_t COL_SHORE = 24'h7799aa;  // stop just above water
	localparam color_t COL_PEAK  = 24'haaaaaa;  // last stop

	// One directed item: water level to hold, height, optional known color
	typedef struct packed {
		logic [HEIGHT_W-1:0] level;
		logic [HEIGHT_W-1:0] height;
		logic                known;
		color_t              color;
	} probe_t;

	localparam int DIR_N = 24;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [HEIGHT_W-1:0] cfg_data = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [HEIGHT_W-1:0] s_tdata = '0;  // height
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [3*CHAN_W-1:0] m_tdata;       // red, green, blue

	color_t color_due [$];
	logic [HEIGHT_W-1:0] water_lvl = '0;
	probe_t probes [DIR_N];
	bit [STOP_COUNT:0] band_seen = '0;
	int idle_pct = 0;
	int stall_pct = 0;
	bit hold_req = 1'b0;
	int fail_cnt = 0;
	int items_sent = 0;
	int colors_checked = 0;
	int levels_written = 0;
	int cyc_cnt = 0;

	height_color_ramp_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Stop height on the height grid, halves rounded away from zero
	function automatic longint stop_grid(input int k);
		longint m;
		m = longint'(STOP_MILLI[k]);
		if (m >= 0)
			return (m * (longint'(1) << FRAC_BITS) + 500) / 1000;
		return -((-m * (longint'(1) << FRAC_BITS) + 500) / 1000);
	endfunction

	// Expected color for one height; band: 0 at or below the first stop, i+1 segment i,
	// STOP_COUNT at or above the last stop
	function automatic color_t ramp_predict(input logic [HEIGHT_W-1:0] height,
			input logic [HEIGHT_W-1:0] level, output int band);
		longint h, lo, hi, w, a, b, acc;
		logic [3*CHAN_W-1:0] ca, cb;
		color_t res;
		bit hit;
		h = longint'($signed(height)) - longint'($signed(level));
		if (h < H_MIN)
			h = H_MIN;
		if (h > H_MAX)
			h = H_MAX;
		hit = 1'b0;
		res = STOP_COLOR[LAST];
		band = STOP_COUNT;
		if (h <= stop_grid(0)) begin
			res = STOP_COLOR[0];
			band = 0;
			hit = 1'b1;
		end else if (h >= stop_grid(LAST)) begin
			hit = 1'b1;
		end
		for (int i = 0; i < LAST && !hit; i++) begin
			lo = stop_grid(i);
			hi = stop_grid(i + 1);
			if (h >= lo && h < hi) begin
				// truncated weight, then rounded blend per channel
				w = ((h - lo) << WEIGHT_BITS) / (hi - lo);
				ca = STOP_COLOR[i];
				cb = STOP_COLOR[i + 1];
				for (int c = 0; c < 3; c++) begin
					a = longint'(ca[CHAN_W*c +: CHAN_W]);
					b = longint'(cb[CHAN_W*c +: CHAN_W]);
					acc = a * (longint'(1) << WEIGHT_BITS) + (b - a) * w
						+ (longint'(1) << (WEIGHT_BITS - 1));
					if (acc < 0)
						acc = 0;
					res[CHAN_W*c +: CHAN_W] = acc[WEIGHT_BITS +: CHAN_W];
				end
				band = i + 1;
				hit = 1'b1;
			end else if (h == lo && hi <= lo) begin
				// coinciding stops: lower stop wins
				res = STOP_COLOR[i];
				band = i + 1;
				hit = 1'b1;
			end
		end
		return res;
	endfunction

	// Random height: mostly across the ramp, some hugging a stop, rest anywhere
	function automatic logic [HEIGHT_W-1:0] pick_height(input logic [HEIGHT_W-1:0] level);
		int r;
		longint off;
		r = $urandom_range(99);
		if (r < 65)
			off = longint'($urandom_range(35000)) - 4000;
		else if (r < 80)
			off = stop_grid($urandom_range(LAST)) + longint'($urandom_range(4)) - 2;
		else
			return HEIGHT_W'($urandom());
		return level + off[HEIGHT_W-1:0];
	endfunction

	task automatic log_failure(input string msg);
		fail_cnt++;
		if (fail_cnt <= MAX_SHOWN)
			$display("[%0t] ERROR: %s", $realtime, msg);
	endtask

	// Offer one height until accepted; file its expected color at acceptance
	task automatic send_height(input logic [HEIGHT_W-1:0] h, input color_t want);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= h;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		color_due.push_back(want);
		items_sent++;
	endtask

	// Water level write, only with the pipe drained
	task automatic set_water_level(input logic [HEIGHT_W-1:0] lvl);
		s_tvalid <= 1'b0;
		while (color_due.size() != 0)
			@(posedge clk);
		repeat (PIPE_LAT) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= lvl;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		water_lvl = lvl;
		levels_written++;
	endtask

	// Receiver: random backpressure, with a long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYC) @(posedge clk);
			end
			m_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Output checker
	always @(posedge clk) begin
		color_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			if (color_due.size() == 0) begin
				log_failure($sformatf("color %h with nothing expected", got));
			end else begin
				want = color_due.pop_front();
				colors_checked++;
				if (got.red !== want.red || got.green !== want.green
						|| got.blue !== want.blue)
					log_failure($sformatf("rgb exp %h/%h/%h got %h/%h/%h",
						want.red, want.green, want.blue,
						got.red, got.green, got.blue));
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cyc_cnt++;
		if (cyc_cnt >= CYCLE_LIMIT) begin
			$display("[%0t] timeout with %0d colors outstanding", $realtime,
				color_due.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		logic [HEIGHT_W-1:0] h;
		color_t want;
		int band;

		// level, height, known, color
		probes = '{
			'{24'h000000, 24'h000000, 1'b1, COL_SEA},
			'{24'h000000, -24'sd2560, 1'b1, COL_DEEP},
			'{24'h000000, 24'h800000, 1'b1, COL_DEEP},
			'{24'h000000, 24'h7fffff, 1'b1, COL_PEAK},
			'{24'h000000, 24'd30720,  1'b1, COL_PEAK},
			'{24'h000000, 24'd30719,  1'b0, '0},
			'{24'h000000, 24'd77,     1'b1, COL_SHORE},
			'{24'h000000, 24'd76,     1'b0, '0},
			'{24'h000000, -24'sd2559, 1'b0, '0},
			'{24'h000000, 24'd1,      1'b0, '0},
			'{24'h000000, 24'd1000,   1'b0, '0},
			'{24'h000000, 24'd20000,  1'b0, '0},
			'{24'h000000, 24'd23039,  1'b0, '0},
			'{24'h000000, -24'sd1,    1'b0, '0},
			// saturating offsets at the level extremes
			'{24'h800000, 24'h7fffff, 1'b1, COL_PEAK},
			'{24'h800000, 24'h800000, 1'b1, COL_SEA},
			'{24'h800000, 24'h000000, 1'b1, COL_PEAK},
			'{24'h7fffff, 24'h800000, 1'b1, COL_DEEP},
			'{24'h7fffff, 24'h7fffff, 1'b1, COL_SEA},
			'{24'h7fffff, 24'h7ffffe, 1'b0, '0},
			'{24'h555555, 24'haaaaaa, 1'b1, COL_DEEP},
			'{24'h2aaaaa, 24'h2abe32, 1'b0, '0},
			'{24'd100,    24'd100,    1'b1, COL_SEA},
			'{24'd100,    24'd177,    1'b1, COL_SHORE}
		};

		repeat (RESET_CYC) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed items, level changes between them when the pipe is empty
		for (int n = 0; n < DIR_N; n++) begin
			if (probes[n].level != water_lvl)
				set_water_level(probes[n].level);
			want = ramp_predict(probes[n].height, water_lvl, band);
			band_seen[band] = 1'b1;
			if (probes[n].known)
				want = probes[n].color;
			send_height(probes[n].height, want);
		end

		// Random phases: each with its own water level and traffic pattern
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: h = 24'(longint'($urandom_range(4095)) - 2048);
				1: h = HEIGHT_W'($urandom());
				2: h = 24'h800000;
				3: h = 24'h7fffff;
				default: h = '0;
			endcase
			set_water_level(h);
			case (p)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 61; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 61; end
				3: begin idle_pct = 12; stall_pct = 12; end
				default: begin
					idle_pct = 0;
					stall_pct = 0;
					hold_req = 1'b1;
				end
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				h = pick_height(water_lvl);
				want = ramp_predict(h, water_lvl, band);
				band_seen[band] = 1'b1;
				send_height(h, want);
			end
		end

		// Drain
		s_tvalid <= 1'b0;
		idle_pct = 0;
		stall_pct = 0;
		while (color_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
		if (color_due.size() != 0)
			log_failure($sformatf("%0d colors never arrived", color_due.size()));

		$display("Sent %0d heights under %0d water levels; %0d colors compared, %0d failures.",
			items_sent, levels_written, colors_checked, fail_cnt);
		$display("Ramp bands reached: %0d of %0d (below first stop, segments, top).",
			$countones(band_seen), STOP_COUNT + 1);
		if (fail_cnt == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
